[sv/alarm_clock_menu_controller_assert.svh]
// Assertion macros for the alarm clock menu controller.
// Used by the top level only; needs nothing else.
`ifndef ALARM_CLOCK_MENU_CONTROLLER_ASSERT_SVH
`define ALARM_CLOCK_MENU_CONTROLLER_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define ACMC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define ACMC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[sv/acmc_pkg.sv]
// Package for the alarm clock menu controller: item types, state codes,
// fixed-point scaling constants and the day wrap helper. No dependencies.
`timescale 1ns / 1ps

package acmc_pkg;

  typedef enum logic [2:0] {
    StHome  = 3'd0,
    StArmed = 3'd1,
    StRing  = 3'd2,
    StMenu  = 3'd3,
    StClkH  = 3'd4,
    StClkM  = 3'd5,
    StAlmH  = 3'd6,
    StAlmM  = 3'd7
  } state_e;

  typedef enum logic [1:0] {
    EvNone = 2'd0,
    EvOne  = 2'd1,
    EvTwo  = 2'd2,
    EvTone = 2'd3
  } event_e;

  localparam logic [16:0] DaySeconds = 17'd86400;
  localparam logic [16:0] SecPerHour = 17'd3600;
  localparam logic [16:0] SecPerMin  = 17'd60;
  localparam logic [10:0] MinPerHour = 11'd60;
  localparam logic [9:0]  KnobHalf   = 10'd512;

  // knob*23/1000 and knob*59/1000 as one multiply by a rounded-up reciprocal;
  // the error stays below the 1/1000 step, so the floor is exact
  localparam logic [20:0] KnobHourMul = 21'd771752;
  localparam logic [20:0] KnobMinMul  = 21'd1979712;
  localparam int unsigned KnobShift   = 25;

  // cur/3600 and cur/60 for cur below one day, same technique
  localparam logic [17:0] Div3600Mul   = 18'd149131;
  localparam int unsigned Div3600Shift = 29;
  localparam logic [17:0] Div60Mul     = 18'd139811;
  localparam int unsigned Div60Shift   = 23;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  knob_sample;
    logic [16:0] uptime_second;
  } acmc_in_t;

  typedef struct packed {
    logic [2:0] state_code;
    logic [4:0] clock_hour;
    logic [5:0] clock_minute;
    logic [4:0] alarm_hour_out;
    logic [5:0] alarm_minute_out;
    logic       armed;
    logic       tone_on;
    logic [5:0] knob_value;
  } acmc_out_t;

  // result fields settled by the front end
  typedef struct packed {
    logic [2:0] state_code;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
    logic       armed;
    logic       tone_on;
    logic [5:0] knob_value;
  } acmc_info_t;

  // item handed from front to back through the queue
  typedef struct packed {
    acmc_info_t  info;
    logic [16:0] up_mod;
    logic [16:0] offset;
  } acmc_rec_t;

  // reduce a sum of two values below one day into the day
  function automatic logic [16:0] wrap_day(input logic [17:0] sum);
    logic [17:0] diff;
    diff = sum - 18'(DaySeconds);
    return (sum >= 18'(DaySeconds)) ? diff[16:0] : sum[16:0];
  endfunction

  function automatic logic [4:0] knob_hour(input logic [9:0] knob);
    logic [30:0] prod;
    prod = 31'(knob) * 31'(KnobHourMul);
    return 5'(prod >> KnobShift);
  endfunction

  function automatic logic [5:0] knob_minute(input logic [9:0] knob);
    logic [30:0] prod;
    prod = 31'(knob) * 31'(KnobMinMul);
    return 6'(prod >> KnobShift);
  endfunction

endpackage

[sv/acmc_front.sv]
// Front end of the alarm clock menu controller: accepts events, runs the
// menu state machine and the settings registers. Depends on acmc_pkg.
`timescale 1ns / 1ps

module acmc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  acmc_pkg::acmc_in_t  in_item_i,
  input  logic                q_ready_i,
  output logic                push_o,
  output acmc_pkg::acmc_rec_t rec_o
);

  acmc_pkg::state_e state_q, state_d;
  logic [16:0] offset_q, offset_d;
  logic [4:0]  set_hour_q, set_hour_d;
  logic [4:0]  alarm_hour_q, alarm_hour_d;
  logic [5:0]  alarm_min_q, alarm_min_d;
  logic [16:0] alarm_sec_q, alarm_sec_d;
  logic        armed_q, armed_d;

  logic             accept;
  acmc_pkg::event_e ev;
  logic [4:0]       hr;
  logic [5:0]       mn;
  logic             choice;
  logic [16:0]      up_mod;
  logic [16:0]      cur_now;
  logic             alarm_hit;
  logic [16:0]      offset_commit;
  logic [16:0]      alarm_commit;
  logic [5:0]       knob_val;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;
  assign push_o     = accept;

  assign ev     = acmc_pkg::event_e'(in_item_i.mode);
  assign hr     = acmc_pkg::knob_hour(in_item_i.knob_sample);
  assign mn     = acmc_pkg::knob_minute(in_item_i.knob_sample);
  assign choice = (in_item_i.knob_sample >= acmc_pkg::KnobHalf);

  assign up_mod    = acmc_pkg::wrap_day({1'b0, in_item_i.uptime_second});
  assign cur_now   = acmc_pkg::wrap_day(18'(up_mod) + 18'(offset_q));
  // an alarm second of a full day never matches, as cur_now stays below it
  assign alarm_hit = (alarm_sec_q == cur_now);

  assign offset_commit = acmc_pkg::wrap_day(18'(set_hour_q) * 18'(acmc_pkg::SecPerHour)
                                            + 18'(mn) * 18'(acmc_pkg::SecPerMin));
  assign alarm_commit  = 17'(17'(alarm_hour_q) * acmc_pkg::SecPerHour
                             + 17'(mn) * acmc_pkg::SecPerMin);

  // next state
  always_comb begin
    state_d = state_q;
    if (accept) begin
      unique case (state_q)
        acmc_pkg::StHome: begin
          unique case (ev)
            acmc_pkg::EvOne: state_d = acmc_pkg::StMenu;
            acmc_pkg::EvTwo: state_d = acmc_pkg::StArmed;
            default:         state_d = acmc_pkg::StHome;
          endcase
        end
        acmc_pkg::StArmed: begin
          priority if (ev == acmc_pkg::EvTwo) state_d = acmc_pkg::StHome;
          else if (alarm_hit || ev == acmc_pkg::EvTone) state_d = acmc_pkg::StRing;
          else if (ev == acmc_pkg::EvOne) state_d = acmc_pkg::StMenu;
          else state_d = acmc_pkg::StArmed;
        end
        acmc_pkg::StRing: begin
          unique case (ev)
            acmc_pkg::EvOne: state_d = acmc_pkg::StArmed;
            acmc_pkg::EvTwo: state_d = acmc_pkg::StHome;
            default:         state_d = acmc_pkg::StRing;
          endcase
        end
        acmc_pkg::StMenu: begin
          unique case (ev)
            acmc_pkg::EvOne:  state_d = choice ? acmc_pkg::StAlmH : acmc_pkg::StClkH;
            acmc_pkg::EvTwo:  state_d = acmc_pkg::StHome;
            acmc_pkg::EvTone: state_d = acmc_pkg::StRing;
            default:          state_d = acmc_pkg::StMenu;
          endcase
        end
        acmc_pkg::StClkH: begin
          unique case (ev)
            acmc_pkg::EvOne: state_d = acmc_pkg::StClkM;
            acmc_pkg::EvTwo: state_d = acmc_pkg::StMenu;
            default:         state_d = acmc_pkg::StClkH;
          endcase
        end
        acmc_pkg::StClkM: begin
          unique case (ev)
            acmc_pkg::EvOne, acmc_pkg::EvTwo: state_d = acmc_pkg::StHome;
            default:                          state_d = acmc_pkg::StClkM;
          endcase
        end
        acmc_pkg::StAlmH: begin
          unique case (ev)
            acmc_pkg::EvOne: state_d = acmc_pkg::StAlmM;
            acmc_pkg::EvTwo: state_d = acmc_pkg::StMenu;
            default:         state_d = acmc_pkg::StAlmH;
          endcase
        end
        acmc_pkg::StAlmM: begin
          unique case (ev)
            acmc_pkg::EvOne: state_d = acmc_pkg::StHome;
            acmc_pkg::EvTwo: state_d = acmc_pkg::StAlmH;
            default:         state_d = acmc_pkg::StAlmM;
          endcase
        end
      endcase
    end
  end

  // settings updates and scaled knob of the screen handling the event
  always_comb begin
    armed_d      = armed_q;
    set_hour_d   = set_hour_q;
    offset_d     = offset_q;
    alarm_hour_d = alarm_hour_q;
    alarm_min_d  = alarm_min_q;
    alarm_sec_d  = alarm_sec_q;
    knob_val     = '0;
    unique case (state_q)
      acmc_pkg::StHome: begin
        if (accept && ev == acmc_pkg::EvTwo) armed_d = 1'b1;
      end
      acmc_pkg::StArmed, acmc_pkg::StRing: begin
        if (accept && ev == acmc_pkg::EvTwo) armed_d = 1'b0;
      end
      acmc_pkg::StMenu: begin
        knob_val = {5'd0, choice};
      end
      acmc_pkg::StClkH: begin
        knob_val = {1'b0, hr};
        if (accept && ev == acmc_pkg::EvOne) set_hour_d = hr;
      end
      acmc_pkg::StClkM: begin
        knob_val = mn;
        if (accept && ev == acmc_pkg::EvOne) offset_d = offset_commit;
      end
      acmc_pkg::StAlmH: begin
        knob_val = {1'b0, hr};
        if (accept && ev == acmc_pkg::EvOne) alarm_hour_d = hr;
      end
      acmc_pkg::StAlmM: begin
        knob_val = mn;
        if (accept && ev == acmc_pkg::EvOne) begin
          alarm_min_d = mn;
          alarm_sec_d = alarm_commit;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= acmc_pkg::StHome;
      offset_q     <= '0;
      set_hour_q   <= '0;
      alarm_hour_q <= '0;
      alarm_min_q  <= '0;
      alarm_sec_q  <= '0;
      armed_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      offset_q     <= offset_d;
      set_hour_q   <= set_hour_d;
      alarm_hour_q <= alarm_hour_d;
      alarm_min_q  <= alarm_min_d;
      alarm_sec_q  <= alarm_sec_d;
      armed_q      <= armed_d;
    end
  end

  always_comb begin
    rec_o.info.state_code   = state_d;
    rec_o.info.alarm_hour   = alarm_hour_d;
    rec_o.info.alarm_minute = alarm_min_d;
    rec_o.info.armed        = armed_d;
    rec_o.info.tone_on      = (state_d == acmc_pkg::StRing);
    rec_o.info.knob_value   = knob_val;
    rec_o.up_mod            = up_mod;
    rec_o.offset            = offset_d;
  end

endmodule

[sv/acmc_fifo.sv]
// Short item queue between front and back end of the alarm clock menu
// controller. Depends on acmc_pkg for the item type and depth.
`timescale 1ns / 1ps

module acmc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  acmc_pkg::acmc_rec_t rec_i,
  output logic                ready_o,
  input  logic                pop_i,
  output logic                valid_o,
  output acmc_pkg::acmc_rec_t rec_o
);

  acmc_pkg::acmc_rec_t              mem_q [acmc_pkg::QDepth];
  logic [acmc_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [acmc_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [acmc_pkg::QCntW-1:0]       count_q, count_d;

  assign ready_o = (count_q != acmc_pkg::QCntW'(acmc_pkg::QDepth));
  assign valid_o = (count_q != '0);
  assign rec_o   = mem_q[rd_ptr_q];

  // pointers wrap naturally, the depth being a power of two
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + acmc_pkg::QCntW'(push_i) - acmc_pkg::QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

[sv/acmc_back.sv]
// Back end of the alarm clock menu controller: three-stage pipeline that
// forms the clock time of day and the result item. Depends on acmc_pkg.
`timescale 1ns / 1ps

module acmc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  acmc_pkg::acmc_rec_t q_rec_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output acmc_pkg::acmc_out_t out_item_o
);

  typedef struct packed {
    acmc_pkg::acmc_info_t info;
    logic [16:0]          cur;
  } s1_t;

  typedef struct packed {
    acmc_pkg::acmc_info_t info;
    logic [4:0]           hour;
    logic [10:0]          q60;
  } s2_t;

  s1_t                 s1_q, s1_d;
  s2_t                 s2_q, s2_d;
  acmc_pkg::acmc_out_t s3_q, s3_d;
  logic                v1_q, v2_q, v3_q;
  logic                en1, en2, en3;
  logic [34:0]         prod_h, prod_m;
  logic [10:0]         min_full;

  // a stage loads when it is empty or its contents move on
  assign en3     = !v3_q || out_ready_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign q_pop_o = q_valid_i && en1;

  assign out_valid_o = v3_q;
  assign out_item_o  = s3_q;

  always_comb begin
    s1_d.info = q_rec_i.info;
    s1_d.cur  = acmc_pkg::wrap_day(18'(q_rec_i.up_mod) + 18'(q_rec_i.offset));
  end

  always_comb begin
    prod_h    = 35'(s1_q.cur) * 35'(acmc_pkg::Div3600Mul);
    prod_m    = 35'(s1_q.cur) * 35'(acmc_pkg::Div60Mul);
    s2_d.info = s1_q.info;
    s2_d.hour = 5'(prod_h >> acmc_pkg::Div3600Shift);
    s2_d.q60  = 11'(prod_m >> acmc_pkg::Div60Shift);
  end

  always_comb begin
    min_full              = s2_q.q60 - 11'(s2_q.hour) * acmc_pkg::MinPerHour;
    s3_d.state_code       = s2_q.info.state_code;
    s3_d.clock_hour       = s2_q.hour;
    s3_d.clock_minute     = min_full[5:0];
    s3_d.alarm_hour_out   = s2_q.info.alarm_hour;
    s3_d.alarm_minute_out = s2_q.info.alarm_minute;
    s3_d.armed            = s2_q.info.armed;
    s3_d.tone_on          = s2_q.info.tone_on;
    s3_d.knob_value       = s2_q.info.knob_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= q_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
    if (en3) s3_q <= s3_d;
  end

endmodule

[sv/alarm_clock_menu_controller.sv]
// Alarm clock menu controller (RTL top level).
// Depends on acmc_pkg, acmc_front, acmc_fifo, acmc_back and the assertion header.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_item_i): one event per item,
//   with the knob reading and the uptime second taken at that event.
//   Output channel (out_valid_o / out_ready_i / out_item_o): one result item
//   for every input item, in order: menu state, clock time, alarm setting,
//   armed flag, tone drive and the scaled knob value.
//   Throughput: one item per cycle while out_ready_i stays high; the menu state
//   machine decides each event in the cycle it is accepted.
//   Path: an accepted item is written to the queue, then passes the pipeline
//   stages in order: the first forms the time of day, the second runs the two
//   reciprocal multiplies, the third splits hours from minutes.
//   Stall: when out_ready_i is low the result pipeline holds; the two-entry
//   queue behind the front end keeps taking items until it fills, and
//   in_ready_o then drops.
//   Reset: the menu returns to home, offset, alarm and armed flag clear, and
//   the queue and pipeline empty; items are taken from the first cycle on.
`timescale 1ns / 1ps
`include "alarm_clock_menu_controller_assert.svh"

module alarm_clock_menu_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  acmc_pkg::acmc_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output acmc_pkg::acmc_out_t out_item_o
);

  logic                push;
  acmc_pkg::acmc_rec_t push_rec;
  logic                q_ready;
  logic                q_valid;
  logic                q_pop;
  acmc_pkg::acmc_rec_t q_rec;

  acmc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_ready_i  (q_ready),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  acmc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rec_o   (q_rec)
  );

  acmc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_rec_i     (q_rec),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  `ACMC_ASSERT_IMPLIES(a_push_in_day, clk_i, rst_ni, push,
    (push_rec.offset < acmc_pkg::DaySeconds) && (push_rec.up_mod < acmc_pkg::DaySeconds),
    "queued item holds a time beyond one day")
  `ACMC_ASSERT_IMPLIES(a_out_time_range, clk_i, rst_ni, out_valid_o,
    (out_item_o.clock_hour <= 5'd23) && (out_item_o.clock_minute <= 6'd59),
    "clock time out of range")
  `ACMC_ASSERT_IMPLIES(a_tone_matches_state, clk_i, rst_ni, out_valid_o,
    out_item_o.tone_on == (out_item_o.state_code == acmc_pkg::StRing),
    "tone drive disagrees with ringing state")
  `ACMC_ASSERT_ALWAYS(a_pop_needs_item, clk_i, rst_ni, !q_pop || q_valid,
    "back end popped an empty queue")

endmodule
